@@ sv/bsws_pkg.sv @@
// Shared constants and types for the bounded stack with search.
package bsws_pkg;

  localparam int DEPTH   = 64;
  localparam int AW      = $clog2(DEPTH);
  localparam int WW      = 32;
  localparam int KIND_W  = 2;
  localparam int STAT_W  = 3;
  localparam int POS_W   = 6;
  localparam int FILL_W  = 7;
  localparam int LIMIT_W = 7;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);
  localparam logic [FILL_W-1:0]  DEPTH_F     = FILL_W'(DEPTH);
  localparam logic [AW-1:0]      CNT_LAST    = AW'(DEPTH - 1);

  // kind[1] selects search; otherwise kind[0] picks pop over push
  localparam int KIND_SEARCH_BIT = 1;
  localparam int KIND_POP_BIT    = 0;

  typedef enum logic [STAT_W-1:0] {
    ST_PUSHED    = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_POPPED    = 3'd2,
    ST_UNDERFLOW = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOTFOUND  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SH_HOLD = 2'd0,
    SH_DOWN = 2'd1,
    SH_UP   = 2'd2
  } shift_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_SCAN = 1'b1
  } state_t;

endpackage

@@ sv/bounded_stack_with_search.sv @@
// Bounded LIFO stack of 32-bit words built from a chain of cells, top in cell 0.
// Push and pop: result registered, valid in the cycle after the request; next request the cycle after.
// Search: the chain rotates once through all DEPTH cells, one compare at the last cell
// per cycle; the result is registered after the rotation ends, busy meanwhile.
// Reset (rst_n low, synchronous): fill 0, limit 50, idle; the receiver cannot stall.
module bounded_stack_with_search (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bsws_pkg::KIND_W-1:0]         in_kind,
  input  logic signed [bsws_pkg::WW-1:0]      in_value,
  input  logic                                cfg_we,
  input  logic [bsws_pkg::LIMIT_W-1:0]        cfg_wdata,
  output logic                                out_valid,
  output logic [bsws_pkg::STAT_W-1:0]         out_status,
  output logic signed [bsws_pkg::WW-1:0]      out_data,
  output logic [bsws_pkg::POS_W-1:0]          out_position,
  output logic [bsws_pkg::FILL_W-1:0]         out_fill
);
  import bsws_pkg::*;

  logic [WW-1:0] cell_word [DEPTH];
  logic [WW-1:0] head_word;
  shift_t        shift;

  state_t             state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [AW-1:0]      cnt_r, cnt_nxt;
  logic [WW-1:0]      key_r, key_nxt;
  logic               found_r, found_nxt;
  logic [AW-1:0]      pos_r, pos_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [WW-1:0]      out_data_r, out_data_nxt;
  logic [POS_W-1:0]   out_pos_r, out_pos_nxt;
  logic [FILL_W-1:0]  out_fill_r, out_fill_nxt;

  logic [FILL_W-1:0]  eff_limit;
  logic [FILL_W-1:0]  scan_off;
  logic               scan_live;
  logic               hit;
  logic [AW-1:0]      hit_pos;

  genvar k;
  generate
    for (k = 0; k < DEPTH; k++) begin : g_cell
      logic [WW-1:0] prev_w;
      logic [WW-1:0] next_w;
      if (k == 0) begin : g_head
        assign prev_w = head_word;
      end else begin : g_body
        assign prev_w = cell_word[k-1];
      end
      if (k == DEPTH - 1) begin : g_tail
        assign next_w = '0;
      end else begin : g_inner
        assign next_w = cell_word[k+1];
      end
      bsws_cell u_cell (
        .clk       (clk),
        .shift     (shift),
        .prev_word (prev_w),
        .next_word (next_w),
        .word      (cell_word[k])
      );
    end
  endgenerate

  // bottom entry sits in cell fill-1; it reaches the last cell after DEPTH-fill steps
  assign eff_limit = (FILL_W'(limit_r) < DEPTH_F) ? FILL_W'(limit_r) : DEPTH_F;
  assign scan_off  = DEPTH_F - fill_r;
  assign scan_live = {1'b0, cnt_r} >= scan_off;
  assign hit       = scan_live && !found_r && (cell_word[DEPTH-1] == key_r);
  assign hit_pos   = cnt_r - scan_off[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    shift          = SH_HOLD;
    head_word      = cell_word[DEPTH-1];
    fill_nxt       = fill_r;
    cnt_nxt        = cnt_r;
    key_nxt        = key_r;
    found_nxt      = found_r;
    pos_nxt        = pos_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_pos_nxt    = out_pos_r;
    out_fill_nxt   = out_fill_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (in_kind[KIND_SEARCH_BIT]) begin
            state_nxt = S_SCAN;
            cnt_nxt   = '0;
            key_nxt   = in_value;
            found_nxt = 1'b0;
            pos_nxt   = '0;
          end else if (in_kind[KIND_POP_BIT]) begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = '0;
            if (fill_r != '0) begin
              shift          = SH_UP;
              fill_nxt       = fill_r - 1'b1;
              out_status_nxt = ST_POPPED;
              out_data_nxt   = cell_word[0];
              out_fill_nxt   = fill_r - 1'b1;
            end else begin
              out_status_nxt = ST_UNDERFLOW;
              out_data_nxt   = '0;
              out_fill_nxt   = fill_r;
            end
          end else begin
            out_valid_nxt = 1'b1;
            out_pos_nxt   = '0;
            out_data_nxt  = in_value;
            if (fill_r < eff_limit) begin
              shift          = SH_DOWN;
              head_word      = in_value;
              fill_nxt       = fill_r + 1'b1;
              out_status_nxt = ST_PUSHED;
              out_fill_nxt   = fill_r + 1'b1;
            end else begin
              out_status_nxt = ST_OVERFLOW;
              out_fill_nxt   = fill_r;
            end
          end
        end
      end
      S_SCAN: begin
        shift   = SH_DOWN;
        cnt_nxt = cnt_r + 1'b1;
        if (hit) begin
          found_nxt = 1'b1;
          pos_nxt   = hit_pos;
        end
        if (cnt_r == CNT_LAST) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = (found_r || hit) ? ST_FOUND : ST_NOTFOUND;
          out_data_nxt   = key_r;
          out_pos_nxt    = (found_r || hit) ? POS_W'(hit ? hit_pos : pos_r) : '0;
          out_fill_nxt   = fill_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r        <= cnt_nxt;
    key_r        <= key_nxt;
    found_r      <= found_nxt;
    pos_r        <= pos_nxt;
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_pos_r    <= out_pos_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign busy         = (state_r == S_SCAN);
  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data     = out_data_r;
  assign out_position = out_pos_r;
  assign out_fill     = out_fill_r;

  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while scan still running");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= DEPTH_F)
    else $error("fill above depth");

  a_pushpop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_kind[KIND_SEARCH_BIT]) |=> out_valid)
    else $error("push/pop request without result next cycle");

  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind[KIND_SEARCH_BIT]) |=> (busy && !out_valid))
    else $error("search request did not start a scan");

  a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_fill == fill_r))
    else $error("reported fill differs from held fill");

endmodule

@@ sv/bsws_cell.sv @@
// One stack cell: holds a word, loads from the neighbor below or above.
module bsws_cell (
  input  logic                    clk,
  input  bsws_pkg::shift_t        shift,
  input  logic [bsws_pkg::WW-1:0] prev_word,
  input  logic [bsws_pkg::WW-1:0] next_word,
  output logic [bsws_pkg::WW-1:0] word
);
  import bsws_pkg::*;

  logic [WW-1:0] word_r;
  logic [WW-1:0] word_nxt;

  always_comb begin
    case (shift)
      SH_DOWN: word_nxt = prev_word;
      SH_UP:   word_nxt = next_word;
      default: word_nxt = word_r;
    endcase
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign word = word_r;

endmodule

@@ tb/bounded_stack_with_search_tb.sv @@
// Self-checking testbench for the bounded stack with search: push, pop, search and limit.
module bounded_stack_with_search_tb;
  import bsws_pkg::*;

  localparam logic [KIND_W-1:0] KIND_PUSH       = 2'd0;
  localparam logic [KIND_W-1:0] KIND_POP        = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SEARCH_ALT = 2'd3;
  localparam int QUIET_LIMIT = 2000;
  localparam int RECENT_MAX  = 24;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [WW-1:0]     value;
  } req_t;

  typedef struct {
    status_t            status;
    logic [WW-1:0]      data;
    logic [POS_W-1:0]   position;
    logic [FILL_W-1:0]  fill;
  } result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        in_kind = '0;
  logic signed [WW-1:0]     in_value = '0;
  logic                     cfg_we = 1'b0;
  logic [LIMIT_W-1:0]       cfg_wdata = '0;
  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic signed [WW-1:0]     out_data;
  logic [POS_W-1:0]         out_position;
  logic [FILL_W-1:0]        out_fill;

  // predictor state
  logic [WW-1:0]      stack_mem [DEPTH];
  int                 fill_cnt = 0;
  logic [LIMIT_W-1:0] limit_reg = LIMIT_RESET;

  req_t          pending_reqs[$];
  result_t       expected_results[$];
  logic [WW-1:0] recent_vals[$];

  int gap_pct = 19;
  int err_cnt = 0;
  int accepted_cnt = 0;
  int max_fill = 0;
  int limit_writes = 0;
  int quiet_cycles = 0;
  int status_seen [6] = '{default: 0};

  bounded_stack_with_search i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data     (out_data),
    .out_position (out_position),
    .out_fill     (out_fill)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic result_t stack_apply(logic [KIND_W-1:0] kind, logic [WW-1:0] word);
    result_t r;
    int      lim;
    bit      hit;
    lim = (int'(limit_reg) < DEPTH) ? int'(limit_reg) : DEPTH;
    r.data = word;
    r.position = '0;
    hit = 1'b0;
    case (kind)
      KIND_PUSH: begin
        if (fill_cnt < lim) begin
          stack_mem[AW'(fill_cnt)] = word;
          fill_cnt++;
          r.status = ST_PUSHED;
        end else begin
          r.status = ST_OVERFLOW;
        end
      end
      KIND_POP: begin
        if (fill_cnt > 0) begin
          fill_cnt--;
          r.status = ST_POPPED;
          r.data = stack_mem[AW'(fill_cnt)];
        end else begin
          r.status = ST_UNDERFLOW;
          r.data = '0;
        end
      end
      default: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < fill_cnt; i++) begin
          if (!hit && stack_mem[AW'(i)] == word) begin
            hit = 1'b1;
            r.status = ST_FOUND;
            r.position = POS_W'(i);
          end
        end
      end
    endcase
    r.fill = FILL_W'(fill_cnt);
    return r;
  endfunction

  task automatic add_req(input logic [KIND_W-1:0] kind, input logic [WW-1:0] value);
    req_t rq;
    rq.kind = kind;
    rq.value = value;
    pending_reqs.push_back(rq);
    if (kind == KIND_PUSH) begin
      recent_vals.push_back(value);
      if (recent_vals.size() > RECENT_MAX) void'(recent_vals.pop_front());
    end
  endtask

  // waits until every request is accepted and every result has come back
  task automatic drain();
    while (pending_reqs.size() != 0 || start || busy || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] v);
    drain();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = v;
    limit_writes++;
    @(negedge clk);
  endtask

  // push-heavy and pop-heavy stretches alternate so the fill sweeps up and down
  task automatic add_random(input int count, input int push_pct);
    int   bias;
    int   r;
    req_t rq;
    for (int j = 0; j < count; j++) begin
      bias = ((j / 40) % 2 == 0) ? push_pct : 25;
      r = $urandom_range(0, 99);
      if (r < bias) rq.kind = KIND_PUSH;
      else if (r < bias + (100 - bias) / 2) rq.kind = KIND_POP;
      else if ($urandom_range(0, 4) == 0) rq.kind = KIND_SEARCH_ALT;
      else rq.kind = KIND_SEARCH;
      r = $urandom_range(0, 9);
      if (rq.kind[KIND_SEARCH_BIT] && recent_vals.size() > 0 && r < 6)
        rq.value = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
      else if (r < 3)
        rq.value = WW'($urandom_range(0, 7)) - WW'(4);
      else if (r == 3)
        rq.value = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7fff_ffff;
      else
        rq.value = $urandom;
      add_req(rq.kind, rq.value);
    end
  endtask

  // request driver
  always @(posedge clk) begin : driver
    req_t rq;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(stack_apply(in_kind, in_value));
        accepted_cnt++;
        if (fill_cnt > max_fill) max_fill = fill_cnt;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
          rq = pending_reqs.pop_front();
          start <= 1'b1;
          in_kind <= rq.kind;
          in_value <= rq.value;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : monitor
    result_t want;
    if (rst_n && out_valid) begin
      if (out_status < 6) status_seen[out_status]++;
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d data %h", out_status, out_data);
        err_cnt++;
      end else begin
        want = expected_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          err_cnt++;
        end
        if (out_data !== want.data) begin
          $error("data: expected %h, got %h", want.data, out_data);
          err_cnt++;
        end
        if (out_position !== want.position) begin
          $error("position: expected %0d, got %0d", want.position, out_position);
          err_cnt++;
        end
        if (out_fill !== want.fill) begin
          $error("fill: expected %0d, got %0d", want.fill, out_fill);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no request and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no activity for %0d cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin : main
    int limits [9] = '{127, 64, 1, 50, 0, 63, 17, 0, 127};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset limit, empty stack, field extremes, duplicates, alternate search code
    add_req(KIND_POP, 32'h0);
    add_req(KIND_SEARCH, 32'h0);
    add_req(KIND_PUSH, 32'h8000_0000);
    add_req(KIND_PUSH, 32'h7fff_ffff);
    add_req(KIND_PUSH, 32'h0);
    add_req(KIND_PUSH, 32'hffff_ffff);
    add_req(KIND_PUSH, 32'h8000_0000);
    add_req(KIND_SEARCH, 32'h8000_0000);
    add_req(KIND_SEARCH_ALT, 32'hffff_ffff);
    add_req(KIND_SEARCH, 32'h1234_5678);
    add_req(KIND_POP, 32'hdead_beef);
    add_req(KIND_POP, 32'h0);
    add_req(KIND_SEARCH_ALT, 32'hffff_ffff);

    // limit below the current fill
    write_limit(LIMIT_W'(2));
    add_req(KIND_PUSH, 32'h5555_5555);
    add_req(KIND_POP, 32'hffff_ffff);
    add_req(KIND_PUSH, 32'haaaa_aaaa);
    add_req(KIND_POP, 32'h0);
    add_req(KIND_PUSH, 32'h0000_0001);
    add_req(KIND_PUSH, 32'hffff_fffe);

    write_limit(LIMIT_W'(0));
    add_req(KIND_PUSH, 32'h0);
    add_req(KIND_POP, 32'h0);
    add_req(KIND_POP, 32'h0);
    add_req(KIND_POP, 32'h0);

    limits[7] = $urandom_range(0, (1 << LIMIT_W) - 1);
    for (int p = 0; p < 9; p++) begin
      write_limit(LIMIT_W'(limits[p]));
      gap_pct = (p == 3) ? 0 : 19;
      if (p == 0) begin
        // limit above depth: fill every entry, then overflow and search the two top entries
        for (int j = fill_cnt; j < DEPTH; j++) add_req(KIND_PUSH, $urandom);
        add_req(KIND_PUSH, $urandom);
        add_req(KIND_SEARCH, recent_vals[recent_vals.size() - 2]);
        add_req(KIND_SEARCH_ALT, recent_vals[recent_vals.size() - 3]);
      end
      add_random(140, 70);
    end
    drain();
    repeat (80) @(negedge clk);

    $display("Covered %0d requests under %0d limit writes; fill peaked at %0d of %0d.",
             accepted_cnt, limit_writes, max_fill, DEPTH);
    $display("Results: %0d push, %0d ovf, %0d pop, %0d unf, %0d found, %0d missing.",
             status_seen[ST_PUSHED], status_seen[ST_OVERFLOW], status_seen[ST_POPPED],
             status_seen[ST_UNDERFLOW], status_seen[ST_FOUND], status_seen[ST_NOTFOUND]);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/bsws_pkg.sv
sv/bsws_cell.sv
sv/bounded_stack_with_search.sv
tb/bounded_stack_with_search_tb.sv
